### rtl/pact_pkg.sv
// ----------------------------------------------------------------------------
// pact_pkg : shared types and constants of the connection tracker
// Field widths, command codes, register indexes and the table entry layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pact_pkg;

   localparam int TABLE_ENTRIES_DEF = 64;

   localparam int CMD_W       = 2;
   localparam int OWNER_W     = 31;
   localparam int ADDR_W      = 64;
   localparam int CFG_W       = 7;
   localparam int COUNT_W     = 7;
   localparam int CSR_INDEX_W = 1;
   localparam int IPV4_W      = 32;

   // commands
   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOTS_IN_USE    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PER_ADDRESS = 1'b1;

   typedef struct packed {
      logic [OWNER_W-1:0] owner;
      logic               family;
      logic [ADDR_W-1:0]  address_high;
      logic [ADDR_W-1:0]  address_low;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

`default_nettype wire

### rtl/pact_table_ram.sv
// ----------------------------------------------------------------------------
// pact_table_ram : connection table storage
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pact_table_ram #(
   parameter int DEPTH = pact_pkg::TABLE_ENTRIES_DEF,
   parameter int WIDTH = pact_pkg::ENTRY_W
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/per_address_connection_tracker_core.sv
// ----------------------------------------------------------------------------
// per_address_connection_tracker_core : per-address connection limit table
// Add, check and delete connection items against a table held in one RAM.
// ----------------------------------------------------------------------------
// Sequence: an item scans the active slots, one RAM read per slot, then
//   finishes; an add into a full table first shifts every slot down, dropping
//   slot 0; an item with no work (tracking off, unused command, check with no
//   limit) goes straight to the finishing step.
// Handshake: one item at a time; busy drops with the strobe, which lasts one
//   cycle and cannot be stalled.
// Reset: clears both registers, then frees every slot in turn with busy high;
//   a write of slots_in_use starts the same sweep.
`timescale 1ns / 1ps
`default_nettype none

module per_address_connection_tracker_core #(
   parameter int TABLE_ENTRIES = pact_pkg::TABLE_ENTRIES_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // command channel
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [pact_pkg::CMD_W-1:0]         req_command,
   input  wire logic                               req_family,
   input  wire logic [pact_pkg::ADDR_W-1:0]        req_address_high,
   input  wire logic [pact_pkg::ADDR_W-1:0]        req_address_low,
   input  wire logic [pact_pkg::OWNER_W-1:0]       req_process_id,
   // result channel
   output logic                                    rsp_valid,
   output logic                                    rsp_limit_exceeded,
   output logic      [pact_pkg::COUNT_W-1:0]       rsp_match_count,
   output logic                                    rsp_evicted_oldest,
   output logic                                    rsp_entry_found,
   // register write channel
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [pact_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [pact_pkg::CFG_W-1:0]         csr_data
);

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int CW = $clog2(TABLE_ENTRIES + 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_FINISH
   } state_type;

   state_type state_ff;

   // configuration registers
   logic [pact_pkg::CFG_W-1:0] slots_ff;
   logic [pact_pkg::CFG_W-1:0] max_ff;

   // captured item
   logic [pact_pkg::CMD_W-1:0]   op_cmd_ff;
   logic                         op_family_ff;
   logic [pact_pkg::ADDR_W-1:0]  op_high_ff;
   logic [pact_pkg::ADDR_W-1:0]  op_low_ff;
   logic [pact_pkg::OWNER_W-1:0] op_owner_ff;
   logic                         op_null_ff;   // item has no effect, zero result

   // sweep control
   logic [CW-1:0] issue_ff;     // next slot to read (or clear)
   logic          vld_ff;       // read data valid this cycle
   logic [AW-1:0] tag_ff;       // slot of the read data
   logic          hit_ff;
   logic [AW-1:0] hit_idx_ff;
   logic [pact_pkg::COUNT_W-1:0] count_ff;

   // result registers
   logic                         rsp_valid_ff;
   logic                         rsp_exceeded_ff;
   logic [pact_pkg::COUNT_W-1:0] rsp_count_ff;
   logic                         rsp_evicted_ff;
   logic                         rsp_found_ff;

   // RAM ports
   logic                         rd_en;
   logic [AW-1:0]                rd_addr;
   logic [pact_pkg::ENTRY_W-1:0] rd_data;
   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   pact_pkg::entry_type          wr_entry;
   pact_pkg::entry_type          rd_entry;
   pact_pkg::entry_type          new_entry;

   logic [CW-1:0] n_w;          // active slots, clamped to the table size
   logic [CW-1:0] last_w;
   logic          scan_done;
   logic          owner_free;
   logic          addr_eq;
   logic          chk_match;
   logic          hit_now;
   logic          accept;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // clamp slots_in_use to the physical table
   always_comb begin
      if (int'(slots_ff) > TABLE_ENTRIES) begin
         n_w = CW'(TABLE_ENTRIES);
      end else begin
         n_w = CW'(slots_ff);
      end
   end

   assign last_w    = n_w - CW'(1);
   assign scan_done = (issue_ff == n_w) && !vld_ff;

   // read issue: one slot per cycle while scanning or shifting
   assign rd_en   = ((state_ff == ST_SCAN) || (state_ff == ST_SHIFT)) && (issue_ff != n_w);
   assign rd_addr = issue_ff[AW-1:0];

   // compare the returned slot against the captured item
   assign rd_entry   = pact_pkg::entry_type'(rd_data);
   assign owner_free = (rd_entry.owner == '0);
   assign addr_eq    = op_family_ff
                     ? ((rd_entry.address_low == op_low_ff) &&
                        (rd_entry.address_high == op_high_ff))
                     : (rd_entry.address_low[pact_pkg::IPV4_W-1:0] ==
                        op_low_ff[pact_pkg::IPV4_W-1:0]);
   assign chk_match  = !owner_free && (rd_entry.family == op_family_ff) && addr_eq;
   assign hit_now    = (op_cmd_ff == pact_pkg::CMD_ADD) ? owner_free
                                                        : (rd_entry.owner == op_owner_ff);

   always_comb begin
      new_entry.owner        = op_owner_ff;
      new_entry.family       = op_family_ff;
      new_entry.address_high = op_high_ff;
      new_entry.address_low  = op_low_ff;
   end

   // single write port: clearing sweep, shift copy, or final update
   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = issue_ff[AW-1:0];
      wr_entry = new_entry;
      case (state_ff)
         ST_CLEAR: begin
            wr_en          = 1'b1;
            wr_entry.owner = '0;
         end
         ST_SHIFT: begin
            // move slot k+1 down into slot k
            wr_en    = vld_ff;
            wr_addr  = tag_ff - AW'(1);
            wr_entry = rd_entry;
         end
         ST_FINISH: begin
            if (!op_null_ff) begin
               if (op_cmd_ff == pact_pkg::CMD_ADD) begin
                  wr_en   = 1'b1;
                  wr_addr = hit_ff ? hit_idx_ff : last_w[AW-1:0];
               end else if ((op_cmd_ff == pact_pkg::CMD_DELETE) && hit_ff) begin
                  wr_en          = 1'b1;
                  wr_addr        = hit_idx_ff;
                  wr_entry.owner = '0;
               end
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   pact_table_ram #(
      .DEPTH (TABLE_ENTRIES),
      .WIDTH (pact_pkg::ENTRY_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // sequencer, registers and result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         slots_ff     <= '0;
         max_ff       <= '0;
         issue_ff     <= '0;
         vld_ff       <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         vld_ff       <= rd_en;
         tag_ff       <= rd_addr;
         if (rd_en) begin
            issue_ff <= issue_ff + CW'(1);
         end

         case (state_ff)
            ST_CLEAR: begin
               // free one slot a cycle across the whole table
               if (issue_ff == CW'(TABLE_ENTRIES - 1)) begin
                  state_ff <= ST_IDLE;
               end else begin
                  issue_ff <= issue_ff + CW'(1);
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  op_cmd_ff    <= req_command;
                  op_family_ff <= req_family;
                  op_high_ff   <= req_address_high;
                  op_low_ff    <= req_address_low;
                  op_owner_ff  <= req_process_id;
                  issue_ff     <= '0;
                  hit_ff       <= 1'b0;
                  count_ff     <= '0;
                  // disabled table, unused command or unlimited check: no work
                  if ((n_w == '0) ||
                      ((req_command != pact_pkg::CMD_ADD) &&
                       (req_command != pact_pkg::CMD_CHECK) &&
                       (req_command != pact_pkg::CMD_DELETE)) ||
                      ((req_command == pact_pkg::CMD_CHECK) && (max_ff == '0))) begin
                     op_null_ff <= 1'b1;
                     state_ff   <= ST_FINISH;
                  end else begin
                     op_null_ff <= 1'b0;
                     state_ff   <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               if (vld_ff) begin
                  if ((op_cmd_ff == pact_pkg::CMD_CHECK) && chk_match) begin
                     count_ff <= count_ff + pact_pkg::COUNT_W'(1);
                  end
                  // hold the first free (add) or first owner match (delete)
                  if (!hit_ff && hit_now) begin
                     hit_ff     <= 1'b1;
                     hit_idx_ff <= tag_ff;
                  end
               end
               if (scan_done) begin
                  if ((op_cmd_ff == pact_pkg::CMD_ADD) && !hit_ff) begin
                     // table full: shift everything down, drop slot 0
                     issue_ff <= CW'(1);
                     state_ff <= ST_SHIFT;
                  end else begin
                     state_ff <= ST_FINISH;
                  end
               end
            end
            ST_SHIFT: begin
               if (scan_done) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               rsp_valid_ff    <= 1'b1;
               rsp_exceeded_ff <= 1'b0;
               rsp_count_ff    <= '0;
               rsp_evicted_ff  <= 1'b0;
               rsp_found_ff    <= 1'b0;
               if (!op_null_ff) begin
                  case (op_cmd_ff)
                     pact_pkg::CMD_ADD: begin
                        rsp_evicted_ff <= !hit_ff;
                     end
                     pact_pkg::CMD_CHECK: begin
                        rsp_count_ff    <= count_ff;
                        rsp_exceeded_ff <= (count_ff >= max_ff);
                     end
                     pact_pkg::CMD_DELETE: begin
                        rsp_found_ff <= hit_ff;
                     end
                     default: begin
                        rsp_found_ff <= 1'b0;
                     end
                  endcase
               end
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase

         // register writes; a slot count write frees the whole table
         if (csr_valid && csr_ready) begin
            case (csr_index)
               pact_pkg::CSR_SLOTS_IN_USE: begin
                  slots_ff <= csr_data;
                  issue_ff <= '0;
                  vld_ff   <= 1'b0;
                  state_ff <= ST_CLEAR;
               end
               pact_pkg::CSR_MAX_PER_ADDRESS: begin
                  max_ff <= csr_data;
               end
               default: begin
                  max_ff <= max_ff;
               end
            endcase
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_limit_exceeded = rsp_exceeded_ff;
   assign rsp_match_count    = rsp_count_ff;
   assign rsp_evicted_oldest = rsp_evicted_ff;
   assign rsp_entry_found    = rsp_found_ff;

   // a result only follows the finishing step
   a_rsp_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_FINISH))
      else $error("result strobe without a finishing step");

   // an accepted item keeps the block busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("block not busy after accepting an item");

   // the table is never written while idle
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !wr_en)
      else $error("table written while idle");

   // a result reports at most one kind of outcome
   a_one_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones({rsp_evicted_oldest, rsp_entry_found,
                                (rsp_match_count != '0)}) <= 1)
      else $error("result mixes outcomes of different commands");

   // a count never exceeds the active slot count
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_match_count) <= int'(n_w)))
      else $error("match count above active slot count");

endmodule

`default_nettype wire
